### hdl/scale_note_quantizer_assert.svh
// Assertion macros shared by the scale note quantizer checkers.
// Depends on nothing; included by files that carry assertions.
`ifndef SCALE_NOTE_QUANTIZER_ASSERT_SVH
`define SCALE_NOTE_QUANTIZER_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define SNQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("snq check failed");

// Next-cycle implication, disabled while rst is high.
`define SNQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("snq check failed");

`endif

### hdl/snq_pkg.sv
// Shared types, constants and pitch-class helpers for the scale note quantizer.
// No dependencies.
`default_nettype none
package snq_pkg;

   localparam int NOTE_W = 7;
   localparam int OUT_W = 8;
   localparam int PC_W = 4;
   localparam int OCT_W = 4;
   localparam int SEL_W = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 7;
   localparam int PITCH_CLASSES = 12;
   localparam int SCALE_KINDS = 11;

   typedef logic [PC_W-1:0] pc_type;
   typedef logic [PITCH_CLASSES-1:0] mask_type;

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_SELECT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_NOTE = 1'b1;

   localparam logic [SEL_W-1:0] SCALE_RESET = 4'd6;
   localparam pc_type ROOT_PC_RESET = 4'd0; // root note 60 is pitch class 0

   // Interval masks, bit k set when k semitones above the root is a degree.
   localparam mask_type SCALE_MASK [SCALE_KINDS] = '{
      12'hAB5,  // major
      12'h5AD,  // natural minor
      12'h295,  // pentatonic
      12'h4E9,  // blues
      12'h6AD,  // dorian
      12'h6B5,  // mixolydian
      12'hFFF,  // chromatic
      12'h9AD,  // harmonic minor
      12'hAAD,  // melodic minor
      12'h555,  // whole tone
      12'hB6D   // diminished
   };

   typedef struct packed {
      logic [NOTE_W-1:0] note;
      logic [OCT_W-1:0]  octave;
      pc_type            pc;
   } split_type;

   // note / 12 by reciprocal: exact for 0..127
   function automatic split_type split_note(input logic [NOTE_W-1:0] note);
      logic [12:0]       prod;
      logic [OCT_W-1:0]  oct;
      logic [NOTE_W-1:0] base;
      split_type         res;
      prod = 13'(note) * 13'd43;
      oct = prod[12:9];
      base = 7'({oct, 3'b000}) + 7'({oct, 2'b00});
      res.note = note;
      res.octave = oct;
      res.pc = PC_W'(note - base);
      return res;
   endfunction

   function automatic pc_type add12(input pc_type a, input pc_type b);
      logic [PC_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 5'd12) begin
         s = s - 5'd12;
      end
      return s[PC_W-1:0];
   endfunction

   function automatic pc_type sub12(input pc_type a, input pc_type b);
      pc_type r;
      if (a >= b) begin
         r = a - b;
      end else begin
         r = a + 4'd12 - b;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### hdl/snq_split.sv
// Input-side split of a note into octave and pitch class.
// Depends on snq_pkg.
`default_nettype none
module snq_split (
   input  wire logic [snq_pkg::NOTE_W-1:0] note,
   output snq_pkg::split_type              split
);

   always_comb begin
      split = snq_pkg::split_note(note);
   end

endmodule
`default_nettype wire

### hdl/snq_match.sv
// Nearest-degree search against the selected scale, plus membership flag.
// Depends on snq_pkg.
`default_nettype none
module snq_match (
   input  wire snq_pkg::split_type          split,
   input  wire logic [snq_pkg::SEL_W-1:0]   scale_sel,
   input  wire snq_pkg::pc_type             root_pc,
   output logic [snq_pkg::OUT_W-1:0]        note_out,
   output logic                             in_scale
);

   snq_pkg::mask_type mask;
   snq_pkg::pc_type   rel;
   snq_pkg::pc_type   iv;
   snq_pkg::pc_type   lo;
   snq_pkg::pc_type   hi;
   snq_pkg::pc_type   best;
   logic              found;
   logic [snq_pkg::OUT_W-1:0] oct_base;

   always_comb begin
      mask = '0;
      if (scale_sel < snq_pkg::SEL_W'(snq_pkg::SCALE_KINDS)) begin
         mask = snq_pkg::SCALE_MASK[scale_sel];
      end
      // interval of the input above the root
      rel = snq_pkg::sub12(split.pc, root_pc);
      iv = rel;
      found = 1'b0;
      // widen outward; on a tie the lower interval sits earlier in the table
      for (int d = 0; d <= snq_pkg::PITCH_CLASSES / 2; d++) begin
         lo = snq_pkg::sub12(rel, snq_pkg::PC_W'(d));
         hi = snq_pkg::add12(rel, snq_pkg::PC_W'(d));
         if (!found) begin
            if (mask[lo] && mask[hi]) begin
               iv = (lo < hi) ? lo : hi;
               found = 1'b1;
            end else if (mask[lo]) begin
               iv = lo;
               found = 1'b1;
            end else if (mask[hi]) begin
               iv = hi;
               found = 1'b1;
            end
         end
      end
      best = snq_pkg::add12(root_pc, iv);
      oct_base = snq_pkg::OUT_W'({split.octave, 3'b000}) +
                 snq_pkg::OUT_W'({split.octave, 2'b00});
      if (scale_sel >= snq_pkg::SEL_W'(snq_pkg::SCALE_KINDS)) begin
         note_out = snq_pkg::OUT_W'(split.note);
         in_scale = 1'b1;
      end else begin
         note_out = oct_base + snq_pkg::OUT_W'(best);
         in_scale = mask[rel];
      end
   end

endmodule
`default_nettype wire

### hdl/scale_note_quantizer.sv
// Scale note quantizer: snaps a MIDI note to the nearest degree of a
// configured scale, keeping the input octave, and flags scale membership.
// One request per clock while req_stall is low; a request passes the input
// register, then the result register. The response register frees as soon
// as the result is taken, so a stalled response holds back new requests only
// once the input register is also full. The user must set the scale code and
// root through the csr port while no request is in flight; not enforced here.
// Depends on snq_pkg, snq_split, snq_match.
`default_nettype none
module scale_note_quantizer (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [snq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [snq_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [snq_pkg::NOTE_W-1:0]         req_note_in,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [snq_pkg::OUT_W-1:0]               rsp_note_out,
   output logic                                    rsp_in_scale
);

   logic [snq_pkg::SEL_W-1:0] scale_sel_ff;
   snq_pkg::pc_type           root_pc_ff;
   snq_pkg::split_type        split_in;
   snq_pkg::split_type        split_ff;
   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic [snq_pkg::OUT_W-1:0] note_out_in;
   logic [snq_pkg::OUT_W-1:0] note_out_ff;
   logic                      in_scale_in;
   logic                      in_scale_ff;
   logic                      out_ready;
   logic                      s1_load;
   snq_pkg::split_type        root_split;

   assign root_split = snq_pkg::split_note(csr_wr_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_sel_ff <= snq_pkg::SCALE_RESET;
         root_pc_ff <= snq_pkg::ROOT_PC_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == snq_pkg::CSR_SCALE_SELECT) begin
            scale_sel_ff <= csr_wr_data[snq_pkg::SEL_W-1:0];
         end else if (csr_index == snq_pkg::CSR_ROOT_NOTE) begin
            root_pc_ff <= root_split.pc;
         end
      end
   end

   snq_split u_split (
      .note  (req_note_in),
      .split (split_in)
   );

   snq_match u_match (
      .split     (split_ff),
      .scale_sel (scale_sel_ff),
      .root_pc   (root_pc_ff),
      .note_out  (note_out_in),
      .in_scale  (in_scale_in)
   );

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_ready;
   assign s1_load = req_valid && !req_stall;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_ready) begin
         out_valid_in = s1_valid_ff;
      end
      // input register fills from the request side even while the output waits
      s1_valid_in = s1_load || (s1_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         split_ff <= split_in;
      end
      if (out_ready && s1_valid_ff) begin
         note_out_ff <= note_out_in;
         in_scale_ff <= in_scale_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_note_out = note_out_ff;
   assign rsp_in_scale = in_scale_ff;

endmodule
`default_nettype wire

### hdl/snq_checker.sv
// Port-level checks for the scale note quantizer, bound to the top level.
// Depends on snq_pkg and scale_note_quantizer_assert.svh.
`default_nettype none
`include "scale_note_quantizer_assert.svh"
module snq_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [snq_pkg::OUT_W-1:0]      rsp_note_out,
   input wire logic                           rsp_in_scale
);

   logic req_acc;
   assign req_acc = req_valid && !req_stall;

   `SNQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_note_out) && $stable(rsp_in_scale))
   `SNQ_ASSERT_IMPL(a_note_range, clock, reset, rsp_valid, rsp_note_out <= 8'd131)
   `SNQ_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   `SNQ_ASSERT_IMPL(a_rsp_source, clock, reset, $rose(rsp_valid), $past(req_acc) || $past(req_acc, 2))

endmodule

bind scale_note_quantizer snq_checker u_snq_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_note_out (rsp_note_out),
   .rsp_in_scale (rsp_in_scale)
);
`default_nettype wire

### tb/snq_tb_pkg.sv
// Scale codes and reset values shared by the quantizer testbench files.
// Depends on nothing.
`timescale 1ns / 1ps
package snq_tb_pkg;

   typedef enum logic [3:0] {
      SC_MAJOR,
      SC_MINOR,
      SC_PENTATONIC,
      SC_BLUES,
      SC_DORIAN,
      SC_MIXOLYDIAN,
      SC_CHROMATIC,
      SC_HARMONIC_MINOR,
      SC_MELODIC_MINOR,
      SC_WHOLE_TONE,
      SC_DIMINISHED,
      SC_PASS_FIRST,
      SC_PASS_LAST = 4'd15
   } scale_code_type;

   localparam logic [6:0] ROOT_RESET = 7'd60;

endpackage

### tb/snq_result_checker.sv
// Watches the csr port and both channels of the scale note quantizer, predicts
// each response from its own copy of the scale settings and compares in order.
// Depends on snq_pkg and snq_tb_pkg.
`timescale 1ns / 1ps
module snq_result_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [snq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [snq_pkg::CSR_DATA_W-1:0] csr_wr_data,
   input  wire logic                           req_valid,
   input  wire logic                           req_stall,
   input  wire logic [snq_pkg::NOTE_W-1:0]     req_note_in,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire logic [snq_pkg::OUT_W-1:0]      rsp_note_out,
   input  wire logic                           rsp_in_scale,
   output int                                  pending,
   output int                                  fail_count,
   output int                                  checked_count
);

   typedef struct packed {
      logic [snq_pkg::NOTE_W-1:0] note_in;
      logic [snq_pkg::OUT_W-1:0]  note_out;
      logic                       in_scale;
   } quantized_type;

   logic [snq_pkg::SEL_W-1:0]  scale_sel;
   logic [snq_pkg::NOTE_W-1:0] root_key;
   quantized_type              expected_notes[$];
   int                         mismatches = 0;
   int                         checked = 0;

   // Nearest scale degree, measured around the pitch-class circle; ties go to
   // the earlier table entry, and the octave of the input is kept.
   function automatic quantized_type quantize_note(
         input logic [snq_pkg::NOTE_W-1:0] note,
         input logic [snq_pkg::SEL_W-1:0]  scale,
         input logic [snq_pkg::NOTE_W-1:0] root);
      logic [47:0]   row;  // interval i in nibble i
      int            count;
      int            octave;
      int            pc;
      int            root_pc;
      int            degree;
      int            gap;
      int            best;
      int            best_gap;
      quantized_type q;
      q.note_in = note;
      q.in_scale = 1'b0;
      if (scale >= snq_pkg::SCALE_KINDS) begin
         q.note_out = {1'b0, note};
         q.in_scale = 1'b1;
         return q;
      end
      case (scale)
         snq_tb_pkg::SC_MAJOR:          begin row = 48'h00000B975420; count = 7;  end
         snq_tb_pkg::SC_MINOR:          begin row = 48'h00000A875320; count = 7;  end
         snq_tb_pkg::SC_PENTATONIC:     begin row = 48'h000000097420; count = 5;  end
         snq_tb_pkg::SC_BLUES:          begin row = 48'h000000A76530; count = 6;  end
         snq_tb_pkg::SC_DORIAN:         begin row = 48'h00000A975320; count = 7;  end
         snq_tb_pkg::SC_MIXOLYDIAN:     begin row = 48'h00000A975420; count = 7;  end
         snq_tb_pkg::SC_CHROMATIC:      begin row = 48'hBA9876543210; count = 12; end
         snq_tb_pkg::SC_HARMONIC_MINOR: begin row = 48'h00000B875320; count = 7;  end
         snq_tb_pkg::SC_MELODIC_MINOR:  begin row = 48'h00000B975320; count = 7;  end
         snq_tb_pkg::SC_WHOLE_TONE:     begin row = 48'h000000A86420; count = 6;  end
         snq_tb_pkg::SC_DIMINISHED:     begin row = 48'h0000B9865320; count = 8;  end
         default:                       begin row = '0;               count = 0;  end
      endcase
      octave = int'(note) / snq_pkg::PITCH_CLASSES;
      pc = int'(note) % snq_pkg::PITCH_CLASSES;
      root_pc = int'(root) % snq_pkg::PITCH_CLASSES;
      best = pc;
      best_gap = 99;
      for (int i = 0; i < count; i++) begin
         degree = (root_pc + int'(row[4*i +: 4])) % snq_pkg::PITCH_CLASSES;
         gap = (degree > pc) ? degree - pc : pc - degree;
         if (gap > 6) begin
            gap = snq_pkg::PITCH_CLASSES - gap;
         end
         if (gap < best_gap) begin
            best_gap = gap;
            best = degree;
         end
         if (degree == pc) begin
            q.in_scale = 1'b1;
         end
      end
      q.note_out = snq_pkg::OUT_W'(octave * snq_pkg::PITCH_CLASSES + best);
      return q;
   endfunction

   always @(posedge clock) begin : watch
      quantized_type want;
      if (reset) begin
         scale_sel = snq_pkg::SCALE_RESET;
         root_key = snq_tb_pkg::ROOT_RESET;
         expected_notes.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == snq_pkg::CSR_SCALE_SELECT) begin
               scale_sel = csr_wr_data[snq_pkg::SEL_W-1:0];
            end else if (csr_index == snq_pkg::CSR_ROOT_NOTE) begin
               root_key = csr_wr_data;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_notes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: unexpected response note_out %0d in_scale %0b",
                           $realtime, rsp_note_out, rsp_in_scale);
               end
            end else begin
               want = expected_notes.pop_front();
               checked++;
               if (rsp_note_out !== want.note_out || rsp_in_scale !== want.in_scale) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: note %0d: expected note_out %0d in_scale %0b, got %0d %0b",
                              $realtime, want.note_in, want.note_out, want.in_scale,
                              rsp_note_out, rsp_in_scale);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_notes.push_back(quantize_note(req_note_in, scale_sel, root_key));
         end
      end
      pending <= expected_notes.size();
      fail_count <= mismatches;
      checked_count <= checked;
   end

   final begin
      if (expected_notes.size() != 0) begin
         $display("%0d expected responses never arrived", expected_notes.size());
      end
   end

endmodule

### tb/tb.sv
// Top of the scale note quantizer testbench: clock, reset, csr writes, request
// and response traffic with random idling, and the verdict.
// Depends on snq_pkg, snq_tb_pkg, snq_result_checker and scale_note_quantizer.
`timescale 1ns / 1ps
module tb;

   localparam int HOLD_CYCLES = 200;
   localparam int STUCK_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_PHASES = 38;
   localparam int PHASE_NOTES = 25;

   logic                           clock;
   logic                           reset;
   logic                           csr_wr_en;
   logic [snq_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [snq_pkg::CSR_DATA_W-1:0] csr_wr_data;
   logic                           req_valid;
   logic                           req_stall;
   logic [snq_pkg::NOTE_W-1:0]     req_note_in;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [snq_pkg::OUT_W-1:0]      rsp_note_out;
   logic                           rsp_in_scale;

   int pending;
   int fail_count;
   int checked_count;
   int stuck_cycles = 0;
   int notes_sent = 0;
   int settings_used = 0;
   bit idle_on = 1'b1;
   bit hold_rsp = 1'b0;
   bit hold_done = 1'b0;

   scale_note_quantizer i_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_note_in  (req_note_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_note_out (rsp_note_out),
      .rsp_in_scale (rsp_in_scale)
   );

   snq_result_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_note_in   (req_note_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_note_out  (rsp_note_out),
      .rsp_in_scale  (rsp_in_scale),
      .pending       (pending),
      .fail_count    (fail_count),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   // Response side: random stalls, plus one long hold-off on request.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         rsp_stall <= idle_on && ($urandom_range(99) < 23);
      end
   end

   task automatic send_note(input logic [snq_pkg::NOTE_W-1:0] note);
      while (idle_on && ($urandom_range(99) < 23)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_note_in <= note;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      notes_sent++;
   endtask

   // Drain everything in flight, then let the pipeline settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_scale(input logic [snq_pkg::SEL_W-1:0] scale,
                            input logic [snq_pkg::NOTE_W-1:0] root);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= snq_pkg::CSR_SCALE_SELECT;
      csr_wr_data <= snq_pkg::CSR_DATA_W'(scale);
      @(posedge clock);
      csr_index <= snq_pkg::CSR_ROOT_NOTE;
      csr_wr_data <= root;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   initial begin
      logic [snq_pkg::NOTE_W-1:0] root;
      logic [snq_pkg::NOTE_W-1:0] note;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= snq_pkg::CSR_SCALE_SELECT;
      csr_wr_data <= '0;
      req_valid <= 1'b0;
      req_note_in <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: chromatic around middle C
      send_note(7'd0);
      send_note(7'd127);
      send_note(7'd61);

      // major on B: circular tie picks the root, top octave spills past 127
      set_scale(snq_tb_pkg::SC_MAJOR, 7'd11);
      send_note(7'd0);
      send_note(7'd120);
      send_note(7'd127);
      send_note(7'd6);

      set_scale(snq_tb_pkg::SC_PENTATONIC, 7'd1);
      send_note(7'd127);
      send_note(7'd124);
      send_note(7'd13);

      // whole tone on C: every odd pitch class is a tie
      set_scale(snq_tb_pkg::SC_WHOLE_TONE, 7'd0);
      send_note(7'd7);
      send_note(7'd127);
      send_note(7'd1);

      set_scale(snq_tb_pkg::SC_PASS_FIRST, 7'd127);
      send_note(7'd127);
      send_note(7'd0);
      send_note(7'd85);

      set_scale(snq_tb_pkg::SC_PASS_LAST, 7'd0);
      send_note(7'd64);
      send_note(7'd1);

      set_scale(snq_tb_pkg::SC_DIMINISHED, 7'd127);
      send_note(7'd127);
      send_note(7'd0);
      send_note(7'd50);

      set_scale(snq_tb_pkg::SC_BLUES, 7'd12);
      send_note(7'd54);
      send_note(7'd1);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 5)
            0:       root = 7'd0;
            1:       root = 7'd127;
            default: root = snq_pkg::NOTE_W'($urandom_range(127));
         endcase
         set_scale(snq_pkg::SEL_W'(p % 16), root);
         idle_on = !(p >= 10 && p < 16);
         if (p == 12) begin
            hold_rsp = 1'b1;
         end
         for (int n = 0; n < PHASE_NOTES; n++) begin
            // top octave gets extra weight for the carries past 127
            if ($urandom_range(99) < 20) begin
               note = snq_pkg::NOTE_W'($urandom_range(127, 120));
            end else begin
               note = snq_pkg::NOTE_W'($urandom_range(127));
            end
            send_note(note);
         end
      end
      idle_on = 1'b1;
      wait_idle();

      $display("%0d notes sent under %0d scale/root settings, %0d responses checked",
               notes_sent, settings_used, checked_count);
      $display("all eleven scales, pass-through codes and roots 0 and 127 exercised");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/snq_pkg.sv
hdl/snq_split.sv
hdl/snq_match.sv
hdl/scale_note_quantizer.sv
hdl/snq_checker.sv
tb/snq_tb_pkg.sv
tb/snq_result_checker.sv
tb/tb.sv
